FILE: hw/rtl/ps2mct_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor tracker.
package ps2mct_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned BTN_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DELTA_W  = 12;

    localparam int unsigned HDR_SYNC_BIT = 3;
    localparam int unsigned HDR_X_SIGN   = 4;
    localparam int unsigned HDR_Y_SIGN   = 5;
    localparam int unsigned HDR_X_OVF    = 6;
    localparam int unsigned HDR_Y_OVF    = 7;

    localparam logic signed [DELTA_W-1:0] OVF_EXTRA = 12'sd255;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } t_pkt;

endpackage

FILE: hw/rtl/ps2mct_assembler.sv
// Packet framing: drops the first byte, syncs on the header bit and gathers three bytes.
module ps2mct_assembler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [ps2mct_pkg::BYTE_W-1:0]   i_byte,
    output logic                            o_done,
    output ps2mct_pkg::t_pkt                o_pkt
);

    typedef enum logic [1:0] {
        ST_SKIP,
        ST_HEADER,
        ST_XBYTE,
        ST_YBYTE
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [ps2mct_pkg::BYTE_W-1:0]  r_header;
    logic [ps2mct_pkg::BYTE_W-1:0]  r_x_byte;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SKIP:   n_state = ST_HEADER;
            ST_HEADER: n_state = i_byte[ps2mct_pkg::HDR_SYNC_BIT] ? ST_XBYTE : ST_HEADER;
            ST_XBYTE:  n_state = ST_YBYTE;
            ST_YBYTE:  n_state = ST_HEADER;
            default:   n_state = ST_HEADER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SKIP;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && (r_state == ST_HEADER) && i_byte[ps2mct_pkg::HDR_SYNC_BIT]) begin
            r_header <= i_byte;
        end
        if (i_adv && (r_state == ST_XBYTE)) begin
            r_x_byte <= i_byte;
        end
    end

    assign o_done        = i_adv && (r_state == ST_YBYTE);
    assign o_pkt.header  = r_header;
    assign o_pkt.x_byte  = r_x_byte;
    assign o_pkt.y_byte  = i_byte;

endmodule

FILE: hw/rtl/ps2mct_axis.sv
// One cursor axis: builds the signed delta, applies it and clamps to the screen.
module ps2mct_axis #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]           i_pos,
    input  logic [ps2mct_pkg::BYTE_W-1:0]   i_mag,
    input  logic                            i_neg,
    input  logic                            i_ovf,
    input  logic                            i_sub,
    input  logic [ps2mct_pkg::SIZE_W-1:0]   i_size,
    output logic [COORD_BITS-1:0]           o_pos
);

    localparam int unsigned SW = (COORD_BITS + 2 > ps2mct_pkg::DELTA_W) ?
                                 COORD_BITS + 2 : ps2mct_pkg::DELTA_W;
    localparam int unsigned LW = (COORD_BITS > ps2mct_pkg::SIZE_W) ?
                                 COORD_BITS : ps2mct_pkg::SIZE_W;

    logic signed [ps2mct_pkg::DELTA_W-1:0]  w_base;
    logic signed [ps2mct_pkg::DELTA_W-1:0]  w_delta;
    logic signed [ps2mct_pkg::DELTA_W-1:0]  w_step;
    logic signed [SW-1:0]                   w_sum;
    logic [ps2mct_pkg::SIZE_W-1:0]          w_size_m1;
    logic [LW-1:0]                          w_lim_ext;
    logic [LW-1:0]                          w_top_ext;
    logic [COORD_BITS-1:0]                  w_lim;

    always_comb begin
        w_base  = ps2mct_pkg::DELTA_W'($signed({i_neg, i_mag}));
        w_delta = w_base;
        if (i_ovf) begin
            w_delta = i_neg ? (w_base - ps2mct_pkg::OVF_EXTRA)
                            : (w_base + ps2mct_pkg::OVF_EXTRA);
        end
        w_step = i_sub ? -w_delta : w_delta;
        w_sum  = $signed(SW'(i_pos)) + SW'(w_step);
    end

    always_comb begin
        w_size_m1 = (i_size == '0) ? '0 : (i_size - ps2mct_pkg::SIZE_W'(1));
        w_lim_ext = LW'(w_size_m1);
        w_top_ext = LW'({COORD_BITS{1'b1}});
        if (w_lim_ext > w_top_ext) begin
            w_lim = {COORD_BITS{1'b1}};
        end else begin
            w_lim = w_lim_ext[COORD_BITS-1:0];
        end
    end

    always_comb begin
        if (w_sum[SW-1]) begin
            o_pos = '0;
        end else if (w_sum[SW-2:0] > (SW-1)'(w_lim)) begin
            o_pos = w_lim;
        end else begin
            o_pos = w_sum[COORD_BITS-1:0];
        end
    end

endmodule

FILE: hw/rtl/ps2_mouse_packet_cursor_tracker.sv
// Top level of the PS/2 mouse packet decoder and clamped cursor tracker.
// A packet's third byte is held in the input register, and its result is then captured in the result register.
// Throughput: one byte per cycle unless a held result is not taken, set by the input register and the result register.
// The packet logic and both axis updates sit between those two registers.
// Reset is synchronous and active low: the first byte is dropped, the cursor returns
// to the origin and the screen size returns to 1024 by 768.
module ps2_mouse_packet_cursor_tracker #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_data_valid,
    output logic                                o_data_ready,
    input  logic [ps2mct_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [COORD_BITS-1:0]               o_cursor_x,
    output logic [COORD_BITS-1:0]               o_cursor_y,
    output logic [ps2mct_pkg::BTN_W-1:0]        o_buttons,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ps2mct_pkg::SIZE_W-1:0]       i_cfg_data
);

    logic                               r_in_valid;
    logic [ps2mct_pkg::BYTE_W-1:0]      r_in_byte;
    logic                               r_out_valid;
    logic [COORD_BITS-1:0]              r_pos_x;
    logic [COORD_BITS-1:0]              r_pos_y;
    logic [ps2mct_pkg::BTN_W-1:0]       r_buttons;
    logic [ps2mct_pkg::SIZE_W-1:0]      r_width;
    logic [ps2mct_pkg::SIZE_W-1:0]      r_height;
    logic                               w_adv;
    logic                               w_done;
    ps2mct_pkg::t_pkt                   w_pkt;
    logic [COORD_BITS-1:0]              n_pos_x;
    logic [COORD_BITS-1:0]              n_pos_y;

    assign w_adv        = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_data_ready = !r_in_valid || w_adv;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_data_ready) begin
            r_in_valid <= i_data_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data_valid && o_data_ready) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2mct_pkg::WIDTH_RESET;
            r_height <= ps2mct_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ps2mct_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                ps2mct_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ps2mct_assembler u_assembler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .o_done  (w_done),
        .o_pkt   (w_pkt)
    );

    ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_pos  (r_pos_x),
        .i_mag  (w_pkt.x_byte),
        .i_neg  (w_pkt.header[ps2mct_pkg::HDR_X_SIGN]),
        .i_ovf  (w_pkt.header[ps2mct_pkg::HDR_X_OVF]),
        .i_sub  (1'b0),
        .i_size (r_width),
        .o_pos  (n_pos_x)
    );

    // Screen rows grow downward, so the Y delta is subtracted.
    ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_pos  (r_pos_y),
        .i_mag  (w_pkt.y_byte),
        .i_neg  (w_pkt.header[ps2mct_pkg::HDR_Y_SIGN]),
        .i_ovf  (w_pkt.header[ps2mct_pkg::HDR_Y_OVF]),
        .i_sub  (1'b1),
        .i_size (r_height),
        .o_pos  (n_pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_buttons <= w_pkt.header[ps2mct_pkg::BTN_W-1:0];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_cursor_x  = r_pos_x;
    assign o_cursor_y  = r_pos_y;
    assign o_buttons   = r_buttons;

    a_pos_held_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("Cursor changed while a result beat was stalled.");

    a_result_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(w_adv))
        else $error("Result appeared without an advancing byte.");

    a_ready_low_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_data_ready |-> (r_in_valid && r_out_valid))
        else $error("Input stalled while the pipeline could advance.");

endmodule
